// ===== rtl/ipv6_text_address_parser_core_defines.svh =====
// Assertion macros shared by the parser RTL.
// Each macro expects clk and arst_n to be visible where it is used.
`ifndef IPV6_TEXT_ADDRESS_PARSER_CORE_DEFINES_SVH
`define IPV6_TEXT_ADDRESS_PARSER_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define IPV6P_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset.
`define IPV6P_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/ipv6p_pkg.sv =====
package ipv6p_pkg;

	localparam int CHAR_W = 8;
	localparam int HALF_W = 64;
	localparam int GROUP_W = 16;
	localparam int GROUP_NUM = 8;

	localparam logic [3:0] GROUPS = 4'd8;
	localparam logic [2:0] MAX_DIGITS = 3'd4;

	localparam logic [7:0] CH_NUL = 8'h00;
	localparam logic [7:0] CH_COLON = 8'h3a;
	localparam logic [7:0] CH_PERCENT = 8'h25;
	localparam logic [7:0] CH_0 = 8'h30;
	localparam logic [7:0] CH_9 = 8'h39;
	localparam logic [7:0] CH_LA = 8'h61;
	localparam logic [7:0] CH_LF = 8'h66;
	localparam logic [7:0] CH_UA = 8'h41;
	localparam logic [7:0] CH_UF = 8'h46;

	typedef logic [GROUP_NUM-1:0][GROUP_W-1:0] group_array_t;

	typedef struct packed {
		group_array_t store;
		logic [3:0] cnt;
		logic [3:0] gap_pos;
		logic gap;
		logic [GROUP_W-1:0] pend;
		logic [2:0] dig;
		logic err;
		logic start;
		logic need2;
		logic stop;
		logic ccg;
	} parse_state_t;

	localparam parse_state_t PARSE_RESET = '{
		store: '0, cnt: 4'd0, gap_pos: 4'd0, gap: 1'b0, pend: '0, dig: 3'd0,
		err: 1'b0, start: 1'b1, need2: 1'b0, stop: 1'b0, ccg: 1'b0
	};

	// Bit 4 flags a hex digit, bits 3:0 carry its value.
	function automatic logic [4:0] hex_decode(input logic [7:0] c);
		logic [7:0] d;
		begin
			d = 8'd0;
			if (c >= CH_0 && c <= CH_9) begin
				d = c - CH_0;
				hex_decode = {1'b1, d[3:0]};
			end else if (c >= CH_LA && c <= CH_LF) begin
				d = c - CH_LA + 8'd10;
				hex_decode = {1'b1, d[3:0]};
			end else if (c >= CH_UA && c <= CH_UF) begin
				d = c - CH_UA + 8'd10;
				hex_decode = {1'b1, d[3:0]};
			end else begin
				hex_decode = 5'd0;
			end
		end
	endfunction

endpackage

// ===== rtl/ipv6p_if.sv =====
interface ipv6p_char_if;
	import ipv6p_pkg::*;

	logic valid;
	logic ready;
	logic [CHAR_W-1:0] char_code;
	logic is_last;

	modport source (output valid, output char_code, output is_last, input ready);
	modport sink (input valid, input char_code, input is_last, output ready);
endinterface

interface ipv6p_addr_if;
	import ipv6p_pkg::*;

	logic valid;
	logic ready;
	logic addr_ok;
	logic [HALF_W-1:0] addr_high;
	logic [HALF_W-1:0] addr_low;

	modport source (output valid, output addr_ok, output addr_high, output addr_low,
		input ready);
	modport sink (input valid, input addr_ok, input addr_high, input addr_low,
		output ready);
endinterface

// ===== rtl/ipv6_text_address_parser_core.sv =====
// The last character word is held in the input stage, then its result loads the result register once free.
// Throughput: one character word per cycle except at the stall; the result register lets the next
// string stream in while an earlier result waits to be taken.
// The only stall is a last character whose result register is still occupied.
// Reset: arst_n clears the input stage, the parse state and the result valid at once.
`include "ipv6_text_address_parser_core_defines.svh"

module ipv6_text_address_parser_core (
	input logic clk,
	input logic arst_n,
	ipv6p_char_if.sink text,
	ipv6p_addr_if.source addr
);
	import ipv6p_pkg::*;

	logic valid_s1;
	logic [CHAR_W-1:0] char_s1;
	logic last_s1;

	parse_state_t st_q;
	parse_state_t nx;

	logic out_valid_q;
	logic ok_q;
	logic [HALF_W-1:0] high_q;
	logic [HALF_W-1:0] low_q;

	logic out_free;
	logic adv;
	logic done;
	logic [4:0] hex;

	logic fin_err;
	logic [3:0] fin_cnt;
	group_array_t fin_store;
	group_array_t fin;
	logic [4:0] reach;

	assign out_free = !out_valid_q || addr.ready;
	assign adv = valid_s1 && (!last_s1 || out_free);
	assign text.ready = !valid_s1 || adv;

	assign addr.valid = out_valid_q;
	assign addr.addr_ok = ok_q;
	assign addr.addr_high = high_q;
	assign addr.addr_low = low_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (text.valid && text.ready) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (text.valid && text.ready) begin
			char_s1 <= text.char_code;
			last_s1 <= text.is_last;
		end
	end

	// Per-character step; once stopped or in error, characters are ignored.
	always_comb begin
		nx = st_q;
		done = 1'b0;
		hex = hex_decode(char_s1);
		if (!st_q.err && !st_q.stop) begin
			if (st_q.ccg) begin
				nx.ccg = 1'b0;
				if (char_s1 == CH_NUL) begin
					nx.err = 1'b1;
					done = 1'b1;
				end
			end
			if (!done) begin
				if (st_q.start) begin
					nx.start = 1'b0;
					if (char_s1 == CH_COLON) begin
						nx.need2 = 1'b1;
						done = 1'b1;
					end
				end else if (st_q.need2) begin
					nx.need2 = 1'b0;
					if (char_s1 != CH_COLON) begin
						nx.err = 1'b1;
						done = 1'b1;
					end
				end
			end
			if (!done) begin
				if (char_s1 == CH_NUL || char_s1 == CH_PERCENT) begin
					nx.stop = 1'b1;
				end else if (hex[4]) begin
					if (st_q.dig >= MAX_DIGITS) begin
						nx.err = 1'b1;
					end else begin
						nx.pend = {st_q.pend[GROUP_W-5:0], hex[3:0]};
						nx.dig = st_q.dig + 3'd1;
					end
				end else if (char_s1 == CH_COLON) begin
					if (st_q.dig == 3'd0) begin
						if (st_q.gap) begin
							nx.err = 1'b1;
						end else begin
							nx.gap = 1'b1;
							nx.gap_pos = st_q.cnt;
						end
					end else if (st_q.cnt >= GROUPS) begin
						nx.err = 1'b1;
					end else begin
						nx.store[st_q.cnt[2:0]] = st_q.pend;
						nx.cnt = st_q.cnt + 4'd1;
						nx.pend = '0;
						nx.dig = 3'd0;
						nx.ccg = 1'b1;
					end
				end else begin
					nx.err = 1'b1;
				end
			end
		end
	end

	// End of string: close the open group, then spread the groups around the gap.
	always_comb begin
		fin_err = nx.err || nx.ccg || nx.need2;
		fin_cnt = nx.cnt;
		fin_store = nx.store;
		fin = '0;
		reach = 5'd0;
		if (!fin_err && nx.dig != 3'd0) begin
			if (fin_cnt >= GROUPS) begin
				fin_err = 1'b1;
			end else begin
				fin_store[fin_cnt[2:0]] = nx.pend;
				fin_cnt = fin_cnt + 4'd1;
			end
		end
		if (!fin_err) begin
			if (nx.gap) begin
				if (fin_cnt >= GROUPS || nx.gap_pos > fin_cnt) begin
					fin_err = 1'b1;
				end else begin
					for (int i = 0; i < GROUP_NUM; i++) begin
						reach = 5'(i) + {1'b0, fin_cnt} - {1'b0, nx.gap_pos};
						if (4'(i) < nx.gap_pos) begin
							fin[i] = fin_store[i];
						end else if (reach >= {1'b0, GROUPS}) begin
							fin[i] = fin_store[3'(i) + fin_cnt[2:0]];
						end
					end
				end
			end else if (fin_cnt != GROUPS) begin
				fin_err = 1'b1;
			end else begin
				fin = fin_store;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= PARSE_RESET;
		end else if (adv) begin
			st_q <= last_s1 ? PARSE_RESET : nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (addr.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && last_s1) begin
			ok_q <= !fin_err;
			high_q <= fin_err ? '0 : {fin[0], fin[1], fin[2], fin[3]};
			low_q <= fin_err ? '0 : {fin[4], fin[5], fin[6], fin[7]};
		end
	end

	`IPV6P_ASSERT_NOW(a_err_zero_addr, out_valid_q && !ok_q, high_q == '0 && low_q == '0,
		"failed address word carries nonzero address bits")
	`IPV6P_ASSERT_NEXT(a_last_gives_result, adv && last_s1, out_valid_q,
		"last character did not produce a result word")
	`IPV6P_ASSERT_NEXT(a_state_restarts, adv && last_s1,
		st_q.start && !st_q.err && !st_q.stop && st_q.cnt == 4'd0 && !st_q.gap,
		"parse state not restarted after end of string")
	`IPV6P_ASSERT_NOW(a_group_bound, 1'b1, st_q.cnt <= GROUPS && st_q.dig <= MAX_DIGITS,
		"group or digit count out of range")

endmodule
